// ===== rtl/core/srt_pkg.sv =====
// Shared types, constants and helpers of the sensor report trigger.
// Used by every module and interface of the block; depends on nothing.
`default_nettype none

package srt_pkg;

	localparam int unsigned CMD_W    = 1;
	localparam int unsigned MV_W     = 13;
	localparam int unsigned HUMI_W   = 10;
	localparam int unsigned CNT_W    = 4;
	localparam int unsigned HB_W     = 12;
	localparam int unsigned CAUSE_W  = 2;
	localparam int unsigned PERIOD_W = 5;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 13;

	// Item kinds.
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b0;
	localparam logic [CMD_W-1:0] CMD_RESULT = 1'b1;

	// Report causes.
	localparam logic [CAUSE_W-1:0] CAUSE_BOOT  = 2'd0;
	localparam logic [CAUSE_W-1:0] CAUSE_DELTA = 2'd1;
	localparam logic [CAUSE_W-1:0] CAUSE_TIMER = 2'd2;

	// Sample periods in seconds.
	localparam logic [PERIOD_W-1:0] PERIOD_USB  = 5'd2;
	localparam logic [PERIOD_W-1:0] PERIOD_BATT = 5'd18;
	localparam logic [PERIOD_W-1:0] PERIOD_LOW  = 5'd28;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_TICKS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELTA_LARGE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELTA_SMALL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_BATT_MV     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_USB_LOW_MV      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_USB_HIGH_MV     = 3'd6;

	// Configuration reset values.
	localparam logic [HB_W-1:0]   RST_HEARTBEAT_TICKS = 12'd330;
	localparam logic [HUMI_W-1:0] RST_DELTA_LARGE     = 10'd30;
	localparam logic [HUMI_W-1:0] RST_DELTA_SMALL     = 10'd10;
	localparam logic [CNT_W-1:0]  RST_CONFIRM_COUNT   = 4'd3;
	localparam logic [MV_W-1:0]   RST_LOW_BATT_MV     = 13'd3000;
	localparam logic [MV_W-1:0]   RST_USB_LOW_MV      = 13'd3270;
	localparam logic [MV_W-1:0]   RST_USB_HIGH_MV     = 13'd3340;

	typedef struct packed {
		logic [HB_W-1:0]   heartbeat_ticks;
		logic [HUMI_W-1:0] delta_large;
		logic [HUMI_W-1:0] delta_small;
		logic [CNT_W-1:0]  confirm_count;
		logic [MV_W-1:0]   low_batt_mv;
		logic [MV_W-1:0]   usb_low_mv;
		logic [MV_W-1:0]   usb_high_mv;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [MV_W-1:0]   vbat_mv;
		logic [HUMI_W-1:0] humi_tenths;
		logic              send_ok;
	} item_t;

	// Control strobe from the pipeline to the state holders.
	typedef struct packed {
		logic  fire;
		item_t item;
	} step_t;

	// Confirmation counters stop at all ones.
	function automatic logic [CNT_W-1:0] sat_inc_cnt(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/srt_if.sv =====
// Channel interfaces of the sensor report trigger: input items and results.
// Depends on srt_pkg for the field widths.
`default_nettype none

interface srt_item_if;
	logic                         valid;
	logic                         ready;
	logic [srt_pkg::CMD_W-1:0]    cmd;
	logic [srt_pkg::MV_W-1:0]     vbat_mv;
	logic [srt_pkg::HUMI_W-1:0]   humi_tenths;
	logic                         send_ok;

	modport source (output valid, cmd, vbat_mv, humi_tenths, send_ok, input ready);
	modport sink (input valid, cmd, vbat_mv, humi_tenths, send_ok, output ready);
endinterface

interface srt_result_if;
	logic                         valid;
	logic                         ready;
	logic                         push_pending;
	logic [srt_pkg::CAUSE_W-1:0]  report_cause;
	logic [srt_pkg::PERIOD_W-1:0] wake_period;
	logic                         battery_low;

	modport source (output valid, push_pending, report_cause, wake_period, battery_low,
		input ready);
	modport sink (input valid, push_pending, report_cause, wake_period, battery_low,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/srt_cfg.sv =====
// Configuration register file of the sensor report trigger.
// Depends on srt_pkg for the register indexes, widths and reset values.
`default_nettype none

module srt_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [srt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [srt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output srt_pkg::cfg_t                         cfg
);

	srt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heartbeat_ticks <= srt_pkg::RST_HEARTBEAT_TICKS;
			cfg_q.delta_large     <= srt_pkg::RST_DELTA_LARGE;
			cfg_q.delta_small     <= srt_pkg::RST_DELTA_SMALL;
			cfg_q.confirm_count   <= srt_pkg::RST_CONFIRM_COUNT;
			cfg_q.low_batt_mv     <= srt_pkg::RST_LOW_BATT_MV;
			cfg_q.usb_low_mv      <= srt_pkg::RST_USB_LOW_MV;
			cfg_q.usb_high_mv     <= srt_pkg::RST_USB_HIGH_MV;
		end else if (cfg_we) begin
			case (cfg_index)
				srt_pkg::CFG_HEARTBEAT_TICKS:
					cfg_q.heartbeat_ticks <= cfg_wdata[srt_pkg::HB_W-1:0];
				srt_pkg::CFG_DELTA_LARGE:
					cfg_q.delta_large <= cfg_wdata[srt_pkg::HUMI_W-1:0];
				srt_pkg::CFG_DELTA_SMALL:
					cfg_q.delta_small <= cfg_wdata[srt_pkg::HUMI_W-1:0];
				srt_pkg::CFG_CONFIRM_COUNT:
					cfg_q.confirm_count <= cfg_wdata[srt_pkg::CNT_W-1:0];
				srt_pkg::CFG_LOW_BATT_MV:
					cfg_q.low_batt_mv <= cfg_wdata[srt_pkg::MV_W-1:0];
				srt_pkg::CFG_USB_LOW_MV:
					cfg_q.usb_low_mv <= cfg_wdata[srt_pkg::MV_W-1:0];
				srt_pkg::CFG_USB_HIGH_MV:
					cfg_q.usb_high_mv <= cfg_wdata[srt_pkg::MV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/srt_supply.sv =====
// Supply classifier of the sensor report trigger: USB and low confirmation
// counters, sample period and low-battery flag. Depends on srt_pkg.
`default_nettype none

module srt_supply (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire srt_pkg::cfg_t                  cfg,
	input  wire srt_pkg::step_t                 step,
	output logic [srt_pkg::PERIOD_W-1:0]        period,
	output logic                                battery_low
);

	logic [srt_pkg::CNT_W-1:0]    usb_cnt_q, usb_cnt_d;
	logic [srt_pkg::CNT_W-1:0]    low_cnt_q, low_cnt_d;
	logic [srt_pkg::PERIOD_W-1:0] period_q, period_d;
	logic                         batt_low_q, batt_low_d;
	logic [srt_pkg::CNT_W-1:0]    usb_inc, low_inc;
	logic                         in_usb, in_low, in_batt;

	assign in_usb  = (step.item.vbat_mv >= cfg.usb_low_mv) &&
		(step.item.vbat_mv < cfg.usb_high_mv);
	assign in_low  = step.item.vbat_mv < cfg.low_batt_mv;
	assign in_batt = step.item.vbat_mv >= cfg.usb_high_mv;
	assign usb_inc = srt_pkg::sat_inc_cnt(usb_cnt_q);
	assign low_inc = srt_pkg::sat_inc_cnt(low_cnt_q);

	// The USB window wins over low, low over battery; a voltage in no class
	// leaves everything as it is.
	always_comb begin
		usb_cnt_d  = usb_cnt_q;
		low_cnt_d  = low_cnt_q;
		period_d   = period_q;
		batt_low_d = batt_low_q;
		if (in_usb) begin
			usb_cnt_d  = usb_inc;
			if (usb_inc >= cfg.confirm_count) begin
				period_d  = srt_pkg::PERIOD_USB;
				usb_cnt_d = '0;
			end
			low_cnt_d  = '0;
			batt_low_d = 1'b0;
		end else if (in_low) begin
			low_cnt_d = low_inc;
			if (low_inc >= cfg.confirm_count) begin
				period_d   = srt_pkg::PERIOD_LOW;
				batt_low_d = 1'b1;
				low_cnt_d  = '0;
			end
			usb_cnt_d = '0;
		end else if (in_batt) begin
			usb_cnt_d  = '0;
			low_cnt_d  = '0;
			period_d   = srt_pkg::PERIOD_BATT;
			batt_low_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usb_cnt_q  <= '0;
			low_cnt_q  <= '0;
			period_q   <= srt_pkg::PERIOD_BATT;
			batt_low_q <= 1'b0;
		end else if (step.fire && (step.item.cmd == srt_pkg::CMD_SAMPLE)) begin
			usb_cnt_q  <= usb_cnt_d;
			low_cnt_q  <= low_cnt_d;
			period_q   <= period_d;
			batt_low_q <= batt_low_d;
		end
	end

	assign period      = period_q;
	assign battery_low = batt_low_q;

endmodule

`default_nettype wire

// ===== rtl/core/srt_report.sv =====
// Report request logic of the sensor report trigger: heartbeat counter,
// humidity delta confirmation, pending flag and cause. Depends on srt_pkg.
`default_nettype none

module srt_report (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire srt_pkg::cfg_t                 cfg,
	input  wire srt_pkg::step_t                step,
	output logic                               pending,
	output logic [srt_pkg::CAUSE_W-1:0]        cause
);

	logic [srt_pkg::HB_W-1:0]    hb_cnt_q, hb_cnt_d, hb_inc;
	logic [srt_pkg::CNT_W-1:0]   near_cnt_q, near_cnt_d, near_inc;
	logic [srt_pkg::HUMI_W-1:0]  latest_q, latest_d;
	logic [srt_pkg::HUMI_W-1:0]  sent_q, sent_d;
	logic                        pending_q, pending_d;
	logic [srt_pkg::CAUSE_W-1:0] cause_q, cause_d;
	logic [srt_pkg::HUMI_W-1:0]  h, delta;

	assign h        = step.item.humi_tenths;
	assign delta    = (h >= sent_q) ? (h - sent_q) : (sent_q - h);
	assign hb_inc   = (hb_cnt_q == {srt_pkg::HB_W{1'b1}}) ? hb_cnt_q :
		hb_cnt_q + srt_pkg::HB_W'(1);
	assign near_inc = srt_pkg::sat_inc_cnt(near_cnt_q);

	// A humidity request in the same sample overrides the timer cause.
	always_comb begin
		hb_cnt_d   = hb_cnt_q;
		near_cnt_d = near_cnt_q;
		latest_d   = latest_q;
		sent_d     = sent_q;
		pending_d  = pending_q;
		cause_d    = cause_q;
		if (step.item.cmd == srt_pkg::CMD_SAMPLE) begin
			hb_cnt_d = hb_inc;
			if (hb_inc >= cfg.heartbeat_ticks) begin
				pending_d = 1'b1;
				cause_d   = srt_pkg::CAUSE_TIMER;
				hb_cnt_d  = '0;
			end
			latest_d = h;
			if (delta >= cfg.delta_large) begin
				pending_d  = 1'b1;
				cause_d    = srt_pkg::CAUSE_DELTA;
				near_cnt_d = '0;
			end else if (delta >= cfg.delta_small) begin
				near_cnt_d = near_inc;
				if (near_inc >= cfg.confirm_count) begin
					pending_d  = 1'b1;
					cause_d    = srt_pkg::CAUSE_DELTA;
					near_cnt_d = '0;
				end
			end else begin
				near_cnt_d = '0;
			end
		end else begin
			pending_d = 1'b0;
			if (step.item.send_ok) begin
				sent_d = latest_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_cnt_q   <= '0;
			near_cnt_q <= '0;
			latest_q   <= '0;
			sent_q     <= '0;
			pending_q  <= 1'b1;
			cause_q    <= srt_pkg::CAUSE_BOOT;
		end else if (step.fire) begin
			hb_cnt_q   <= hb_cnt_d;
			near_cnt_q <= near_cnt_d;
			latest_q   <= latest_d;
			sent_q     <= sent_d;
			pending_q  <= pending_d;
			cause_q    <= cause_d;
		end
	end

	assign pending = pending_q;
	assign cause   = cause_q;

endmodule

`default_nettype wire

// ===== rtl/core/sensor_report_trigger_top.sv =====
// Top level of the sensor report trigger: input register, state update and
// result valid. Depends on srt_pkg, srt_if, srt_cfg, srt_supply and srt_report.
//
// Usage. Items arrive on the valid/ready channel "item": a sample tick
// (cmd = 0) carries the supply voltage in mV and the humidity in tenths of
// a percent, a transmission result (cmd = 1) carries send_ok. Every item
// yields exactly one transfer on the "result" channel, holding the state
// after that item: push_pending, report_cause, wake_period, battery_low.
// The item is captured in the input register at its transfer; when it moves
// on, the supply and report state registers take their new values, which are
// the result payload. Throughput is one item per cycle while the receiver
// takes each result; the limit is the single state update per cycle, which
// each item needs before the next one can be evaluated. When the receiver
// stalls, the result holds, the item waiting in the input register holds as
// well, and "item" still takes one transfer into an empty input register
// before ready drops. The user writes the configuration through the plain
// write port (cfg_we, cfg_index, cfg_wdata) only while no item is in flight;
// the block does not enforce it. After reset the configuration holds its
// default values, the period is 18, and a boot report is pending (cause 0).
`default_nettype none

module sensor_report_trigger_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [srt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [srt_pkg::CFG_DATA_W-1:0] cfg_wdata,
	srt_item_if.sink                            item,
	srt_result_if.source                        result
);

	srt_pkg::cfg_t  cfg;
	srt_pkg::item_t item_s1;
	srt_pkg::step_t step;
	logic           valid_s1;
	logic           out_valid_q;
	logic           advance;

	// The item in the input register moves on when the result slot is free
	// or is being emptied in this cycle.
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.cmd         <= item.cmd;
			item_s1.vbat_mv     <= item.vbat_mv;
			item_s1.humi_tenths <= item.humi_tenths;
			item_s1.send_ok     <= item.send_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign step.fire = advance;
	assign step.item = item_s1;

	srt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The state registers of both units are the result register: they change
	// only when a new result is loaded, so a stalled result holds.
	srt_supply u_supply (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step        (step),
		.period      (result.wake_period),
		.battery_low (result.battery_low)
	);

	srt_report u_report (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (step),
		.pending (result.push_pending),
		.cause   (result.report_cause)
	);

	assign result.valid = out_valid_q;

	// A transmission result always clears the request it answers.
	a_result_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (item_s1.cmd == srt_pkg::CMD_RESULT)) |=> !result.push_pending)
		else $error("pending request survived a transmission result");

	// The low-battery flag is only ever set together with the long period.
	a_low_flag_period: assert property (@(posedge clk) disable iff (!arst_n)
		result.battery_low |-> (result.wake_period == srt_pkg::PERIOD_LOW))
		else $error("battery low flag without the low-battery period");

	// The period is always one of the three supply modes.
	a_period_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(result.wake_period == srt_pkg::PERIOD_USB) ||
		(result.wake_period == srt_pkg::PERIOD_BATT) ||
		(result.wake_period == srt_pkg::PERIOD_LOW))
		else $error("sample period outside the supply modes");

	// Back pressure on the input only arises with a held item.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (valid_s1 && out_valid_q && !result.ready))
		else $error("input stalled without a held item and a stalled result");

	// A state update always produces a result in the next cycle.
	a_update_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result.valid)
		else $error("state update without a result");

endmodule

`default_nettype wire
